// ===== sv/stfh_pkg.sv =====
// ----------------------------------------------------------------------------
// stfh_pkg
// Shared constants and hash step functions for the filtered text hash.
// ----------------------------------------------------------------------------
package stfh_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned HashW = 32;
    localparam int unsigned ModeW = 3;

    // Filter modes.
    localparam logic [ModeW-1:0] MODE_NORMAL        = 3'd0;
    localparam logic [ModeW-1:0] MODE_SLASH         = 3'd1;
    localparam logic [ModeW-1:0] MODE_COMMENT       = 3'd2;
    localparam logic [ModeW-1:0] MODE_BRACE         = 3'd3;
    localparam logic [ModeW-1:0] MODE_BRACE_SLASH   = 3'd4;
    localparam logic [ModeW-1:0] MODE_BRACE_COMMENT = 3'd5;

    // Characters that steer the filter.
    localparam logic [ByteW-1:0] CH_NUL     = 8'h00;
    localparam logic [ByteW-1:0] CH_TAB     = 8'h09;
    localparam logic [ByteW-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
    localparam logic [ByteW-1:0] CH_SLASH   = 8'h2F;
    localparam logic [ByteW-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [ByteW-1:0] CH_RBRACE  = 8'h7D;

    // One byte step of the one-at-a-time hash; the byte is sign-extended.
    function automatic logic [HashW-1:0] mix_in(input logic [HashW-1:0] h_in,
                                                input logic [ByteW-1:0] b);
        logic [HashW-1:0] h;
        h = h_in + {{(HashW-ByteW){b[ByteW-1]}}, b};
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    // Closing avalanche of the hash.
    function automatic logic [HashW-1:0] mix_final(input logic [HashW-1:0] h_in);
        logic [HashW-1:0] h;
        h = h_in + (h_in << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

endpackage

// ===== sv/source_text_filtered_hash.sv =====
// ----------------------------------------------------------------------------
// source_text_filtered_hash
// One-at-a-time hash of shader source text with whitespace, line comments
// and empty brace pairs filtered out.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer and accepts a new transfer in
// every cycle while the output side keeps up. Blanks (space, tab, newline)
// are dropped, a "//" comment is dropped through its newline, and an opening
// brace followed only by blanks and comments and then a closing brace is
// dropped as a pair; a lone slash and an opening brace are therefore held
// back until a later byte decides them. An end transfer (tuser set, or a
// data byte of zero) flushes any held characters, resets the running state
// and presents the finalized hash through the finalize stage and output register.
// The running hash and filter mode form a registered loop in which a single
// byte can chain up to three byte mixes; the finalizing mix sits in its own
// register stage after that loop. Input is held off only while both the
// finalize stage and the output register are full and the output is stalled.
// ----------------------------------------------------------------------------
module source_text_filtered_hash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [stfh_pkg::ByteW-1:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]                  s_tuser,   // [0] kind (1 = end of text)
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [stfh_pkg::HashW-1:0]  m_tdata    // [31:0] hash_value
);
    import stfh_pkg::*;

    logic [HashW-1:0] hash_reg;
    logic [HashW-1:0] hash_next;
    logic [ModeW-1:0] mode_reg;
    logic [ModeW-1:0] mode_next;

    // Finalize stage: flushed hash of a finished text, waiting for the mix.
    logic             fin_valid_reg;
    logic [HashW-1:0] fin_hash_reg;
    logic [HashW-1:0] fin_hash_next;

    // Output register.
    logic             out_valid_reg;
    logic [HashW-1:0] out_hash_reg;

    logic             out_free;
    logic             fin_free;
    logic             in_xfer;
    logic             is_end;

    assign out_free = !out_valid_reg || m_tready;
    assign fin_free = !fin_valid_reg || out_free;
    assign s_tready = fin_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign is_end   = s_tuser[0] || (s_tdata == CH_NUL);

    // Filter and hash update for the byte on the input.
    always_comb
    begin
        logic [HashW-1:0] h;
        logic             plain;
        h             = hash_reg;
        plain         = 1'b0;
        mode_next     = mode_reg;
        fin_hash_next = hash_reg;

        if (is_end)
        begin
            // Held characters are hashed in order, brace before slash.
            case (mode_reg)
                MODE_SLASH:
                    h = mix_in(h, CH_SLASH);
                MODE_BRACE, MODE_BRACE_COMMENT:
                    h = mix_in(h, CH_LBRACE);
                MODE_BRACE_SLASH:
                    h = mix_in(mix_in(h, CH_LBRACE), CH_SLASH);
                default:
                    h = hash_reg;
            endcase
            fin_hash_next = h;
            h             = '0;
            mode_next     = MODE_NORMAL;
        end
        else
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (s_tdata == CH_SLASH)
                        mode_next = MODE_COMMENT;
                    else
                    begin
                        h     = mix_in(h, CH_SLASH);
                        plain = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (s_tdata == CH_NEWLINE)
                        mode_next = MODE_NORMAL;
                end
                MODE_BRACE:
                begin
                    if (is_blank(s_tdata))
                        mode_next = MODE_BRACE;
                    else if (s_tdata == CH_SLASH)
                        mode_next = MODE_BRACE_SLASH;
                    else if (s_tdata == CH_RBRACE)
                        mode_next = MODE_NORMAL;
                    else
                    begin
                        h     = mix_in(h, CH_LBRACE);
                        plain = 1'b1;
                    end
                end
                MODE_BRACE_SLASH:
                begin
                    if (s_tdata == CH_SLASH)
                        mode_next = MODE_BRACE_COMMENT;
                    else
                    begin
                        h     = mix_in(mix_in(h, CH_LBRACE), CH_SLASH);
                        plain = 1'b1;
                    end
                end
                MODE_BRACE_COMMENT:
                begin
                    if (s_tdata == CH_NEWLINE)
                        mode_next = MODE_BRACE;
                end
                default:
                    plain = 1'b1;
            endcase

            // A byte seen with nothing held back and no open comment.
            if (plain)
            begin
                if (is_blank(s_tdata))
                    mode_next = MODE_NORMAL;
                else if (s_tdata == CH_SLASH)
                    mode_next = MODE_SLASH;
                else if (s_tdata == CH_LBRACE)
                    mode_next = MODE_BRACE;
                else
                begin
                    h         = mix_in(h, s_tdata);
                    mode_next = MODE_NORMAL;
                end
            end
        end
        hash_next = h;
    end

    // Running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            mode_reg <= MODE_NORMAL;
        end
        else if (in_xfer)
        begin
            hash_reg <= hash_next;
            mode_reg <= mode_next;
        end
    end

    // Finalize stage and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= fin_valid_reg;
            if (fin_free)
                fin_valid_reg <= in_xfer && is_end;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (out_free && fin_valid_reg)
            out_hash_reg <= mix_final(fin_hash_reg);
        if (in_xfer && is_end)
            fin_hash_reg <= fin_hash_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

endmodule

// ===== sv/stfh_checker.sv =====
// ----------------------------------------------------------------------------
// stfh_checker
// Port-level checks for the filtered text hash, bound to the top level.
// ----------------------------------------------------------------------------
module stfh_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [stfh_pkg::ByteW-1:0]  s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [stfh_pkg::HashW-1:0]  m_tdata
);
    import stfh_pkg::*;

    logic end_xfer;

    assign end_xfer = s_tvalid && s_tready && (s_tuser[0] || (s_tdata == CH_NUL));

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

    // The input is held off only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

    // An end transfer's result appears, after the finalize stage, when the output drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        end_xfer ##1 m_tready |=> m_tvalid)
    else $error("result of an end transfer did not appear");

endmodule

bind source_text_filtered_hash stfh_checker u_stfh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
